>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL files.
// Needs a clock named clk and a reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SPDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define SPDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/spdc_pkg.sv
// Package for the shortest path distance point counter.
// Types, sizes, register indexes and helper functions; no dependencies.
`default_nettype none
package spdc_pkg;
  localparam int MAX_NODES = 1024;
  localparam int MAX_ROADS = 2048;
  localparam int NODE_AW   = $clog2(MAX_NODES);
  localparam int ROAD_AW   = $clog2(MAX_ROADS);
  localparam int CITY_W    = 11;
  localparam int LEN_W     = 10;
  localparam int DIST_W    = 20;
  localparam int TGT_W     = 30;
  localparam int CNT_W     = 13;
  localparam int EXT_W     = 32;

  // configuration register indexes
  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_SOURCE     = 2'd1;
  localparam logic [1:0] REG_TARGET     = 2'd2;

  typedef struct packed {
    logic [CITY_W-1:0] a;
    logic [CITY_W-1:0] b;
    logic [LEN_W-1:0]  len;
  } road_word_t;

  typedef struct packed {
    logic              settled;
    logic              unreached;
    logic [DIST_W-1:0] d;
  } dist_word_t;

  localparam int ROAD_WW = $bits(road_word_t);
  localparam int DIST_WW = $bits(dist_word_t);

  // unreached reads as a value above any target
  localparam logic [EXT_W-1:0] FAR_EXT = 32'h7FFF_FFFF;

  function automatic logic city_ok(input logic [CITY_W-1:0] c,
                                   input logic [CITY_W-1:0] cities);
    return (c != '0) && (c <= cities);
  endfunction

  function automatic logic [EXT_W-1:0] dist_ext(input dist_word_t w);
    return w.unreached ? FAR_EXT : {{(EXT_W-DIST_W){1'b0}}, w.d};
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/spdc_road_if.sv
// Road input channel: valid/ready handshake with one road per item.
// Depends on spdc_pkg.
`default_nettype none
interface spdc_road_if;
  import spdc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CITY_W-1:0] end_a;
  logic [CITY_W-1:0] end_b;
  logic [LEN_W-1:0]  road_length;
  logic              last_road;
  modport source (output valid, end_a, end_b, road_length, last_road, input ready);
  modport sink (input valid, end_a, end_b, road_length, last_road, output ready);
endinterface
`default_nettype wire

>>> rtl/core/spdc_result_if.sv
// Result channel: valid/ready handshake with one count item per graph.
// Depends on spdc_pkg.
`default_nettype none
interface spdc_result_if;
  import spdc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] point_count;
  logic             road_overflow;
  modport source (output valid, point_count, road_overflow, input ready);
  modport sink (input valid, point_count, road_overflow, output ready);
endinterface
`default_nettype wire

>>> rtl/core/spdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module spdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/spdc_judge.sv
// Per-road point count: how many points inside one road sit at the target.
// Depends on spdc_pkg.
`default_nettype none
module spdc_judge (
  input  wire logic [spdc_pkg::EXT_W-1:0] dist_a,
  input  wire logic [spdc_pkg::EXT_W-1:0] dist_b,
  input  wire logic [spdc_pkg::LEN_W-1:0] len,
  input  wire logic [spdc_pkg::TGT_W-1:0] target,
  output logic      [1:0]                 add
);
  import spdc_pkg::*;

  logic [EXT_W-1:0] dx, dy;
  logic [EXT_W:0]   t_ext, sx, sy;
  logic [EXT_W+1:0] both, twice;

  always_comb begin
    t_ext = {{(EXT_W+1-TGT_W){1'b0}}, target};
    // put end a first unless it is at or past the target
    if ({1'b0, dist_a} >= t_ext) begin
      dx = dist_b;
      dy = dist_a;
    end else begin
      dx = dist_a;
      dy = dist_b;
    end
    sx    = {1'b0, dx} + {{(EXT_W+1-LEN_W){1'b0}}, len};
    sy    = {1'b0, dy} + {{(EXT_W+1-LEN_W){1'b0}}, len};
    both  = {1'b0, sx} + {2'b00, dy};
    twice = {t_ext, 1'b0};
    add   = 2'd0;
    if ({1'b0, dx} < t_ext && sx > t_ext && sy > t_ext) begin
      if ({1'b0, dy} < t_ext) begin
        add = (both == twice) ? 2'd1 : 2'd2;
      end else if ({1'b0, dy} > t_ext) begin
        add = 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/shortest_path_distance_point_count_unit.sv
// Shortest path distance point counter, top level.
// Depends on spdc_pkg, spdc_road_if, spdc_result_if, spdc_ram, spdc_judge, assert_macros.svh.
//
// Use: roads come in on the road channel, one per item, and are taken one
// per cycle while the block is idle. Roads past 2048 are dropped and the
// overflow flag of the next result is set. The road marked last_road starts
// a run: a distance sweep over the cities, then Dijkstra with a linear
// minimum scan and a relax pass over the stored roads for each settled
// city, then a count pass over the cities and the stored roads. The block
// takes no road during a run. One result item follows each last road; it
// is held in an output register until taken, and the next graph may load
// while it waits. Configuration is written through cfg_we, cfg_index and
// cfg_data. Reset (rst, synchronous) empties the road store and clears
// the flag.
`default_nettype none
`include "assert_macros.svh"
module shortest_path_distance_point_count_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  spdc_road_if.sink                        road,
  spdc_result_if.source                    result,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [spdc_pkg::TGT_W-1:0]  cfg_data
);
  import spdc_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INIT    = 4'd1;
  localparam logic [3:0] S_SRC     = 4'd2;
  localparam logic [3:0] S_SCAN_RD = 4'd3;
  localparam logic [3:0] S_SCAN_EV = 4'd4;
  localparam logic [3:0] S_MARK    = 4'd5;
  localparam logic [3:0] S_RX_RD   = 4'd6;
  localparam logic [3:0] S_RX_ROAD = 4'd7;
  localparam logic [3:0] S_RX_DIST = 4'd8;
  localparam logic [3:0] S_CNT_RD  = 4'd9;
  localparam logic [3:0] S_CNT_EV  = 4'd10;
  localparam logic [3:0] S_CR_RD   = 4'd11;
  localparam logic [3:0] S_CR_A    = 4'd12;
  localparam logic [3:0] S_CR_B    = 4'd13;
  localparam logic [3:0] S_CR_J    = 4'd14;
  localparam logic [3:0] S_DONE    = 4'd15;

  localparam logic [CITY_W-1:0]  NODES_CAP = CITY_W'(MAX_NODES);
  localparam logic [ROAD_AW:0]   ROADS_CAP = (ROAD_AW+1)'(MAX_ROADS);

  // configuration
  logic [CITY_W-1:0] node_count, source_node;
  logic [TGT_W-1:0]  target_distance;

  // control and working registers
  logic [3:0]         state;
  logic [ROAD_AW:0]   road_total, ridx;
  logic               overflow_seen;
  logic [CITY_W-1:0]  idx;
  logic [NODE_AW-1:0] pick, other;
  logic [DIST_W-1:0]  low;
  logic               found;
  logic [CITY_W-1:0]  rb;
  logic [LEN_W-1:0]   rlen;
  logic [EXT_W-1:0]   dx;
  logic [CNT_W-1:0]   total;
  logic               res_valid;
  logic [CNT_W-1:0]   res_count;
  logic               res_over;

  // memories
  logic                road_we;
  road_word_t          road_wdata, road_rdata;
  logic [ROAD_WW-1:0]  road_rbits;
  logic                dist_we;
  logic [NODE_AW-1:0]  dist_waddr, dist_raddr;
  dist_word_t          dist_wdata, dist_rdata;
  logic [DIST_WW-1:0]  dist_rbits;

  logic [CITY_W-1:0]  cities, src_m1, a_m1, b_m1, rb_m1;
  logic               src_ok, road_ok, hit_a, hit_b, accept, upd;
  logic [DIST_W:0]    cand;
  logic [1:0]         add;

  assign road_rdata = road_word_t'(road_rbits);
  assign dist_rdata = dist_word_t'(dist_rbits);

  spdc_ram #(.WIDTH(ROAD_WW), .DEPTH(MAX_ROADS)) u_road_ram (
    .clk   (clk),
    .we    (road_we),
    .waddr (road_total[ROAD_AW-1:0]),
    .wdata (road_wdata),
    .raddr (ridx[ROAD_AW-1:0]),
    .rdata (road_rbits)
  );

  spdc_ram #(.WIDTH(DIST_WW), .DEPTH(MAX_NODES)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rbits)
  );

  spdc_judge u_judge (
    .dist_a (dx),
    .dist_b (dist_ext(dist_rdata)),
    .len    (rlen),
    .target (target_distance),
    .add    (add)
  );

  // derived values
  always_comb begin
    cities  = (node_count > NODES_CAP) ? NODES_CAP : node_count;
    src_ok  = city_ok(source_node, cities);
    src_m1  = source_node - CITY_W'(1);
    a_m1    = road_rdata.a - CITY_W'(1);
    b_m1    = road_rdata.b - CITY_W'(1);
    rb_m1   = rb - CITY_W'(1);
    road_ok = city_ok(road_rdata.a, cities) && city_ok(road_rdata.b, cities);
    hit_a   = road_ok && (a_m1[NODE_AW-1:0] == pick);
    hit_b   = road_ok && (b_m1[NODE_AW-1:0] == pick);
    cand    = {1'b0, low} + {{(DIST_W+1-LEN_W){1'b0}}, rlen};
    upd     = dist_rdata.unreached || (cand < {1'b0, dist_rdata.d});
    accept  = road.valid && road.ready;
  end

  assign road.ready         = (state == S_IDLE);
  assign result.valid       = res_valid;
  assign result.point_count = res_count;
  assign result.road_overflow = res_over;

  // road store write on accept
  always_comb begin
    road_we        = accept && (road_total < ROADS_CAP);
    road_wdata.a   = road.end_a;
    road_wdata.b   = road.end_b;
    road_wdata.len = road.road_length;
  end

  // distance memory port control
  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = idx[NODE_AW-1:0];
    dist_wdata = '{settled: 1'b0, unreached: 1'b1, d: '0};
    dist_raddr = idx[NODE_AW-1:0];
    case (state)
      S_INIT: begin
        dist_we = (idx != cities);
      end
      S_SRC: begin
        dist_we    = src_ok;
        dist_waddr = src_m1[NODE_AW-1:0];
        dist_wdata = '{settled: 1'b0, unreached: 1'b0, d: '0};
      end
      S_MARK: begin
        dist_we    = 1'b1;
        dist_waddr = pick;
        dist_wdata = '{settled: 1'b1, unreached: 1'b0, d: low};
      end
      S_RX_ROAD: begin
        dist_raddr = hit_a ? b_m1[NODE_AW-1:0] : a_m1[NODE_AW-1:0];
      end
      S_RX_DIST: begin
        dist_we    = upd;
        dist_waddr = other;
        dist_wdata = '{settled: dist_rdata.settled, unreached: 1'b0,
                       d: cand[DIST_W-1:0]};
      end
      S_CR_A: begin
        dist_raddr = a_m1[NODE_AW-1:0];
      end
      S_CR_B: begin
        dist_raddr = rb_m1[NODE_AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count      <= CITY_W'(2);
      source_node     <= CITY_W'(1);
      target_distance <= TGT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NODE_COUNT: node_count      <= cfg_data[CITY_W-1:0];
        REG_SOURCE:     source_node     <= cfg_data[CITY_W-1:0];
        REG_TARGET:     target_distance <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      road_total    <= '0;
      overflow_seen <= 1'b0;
      res_valid     <= 1'b0;
      idx           <= '0;
      ridx          <= '0;
      found         <= 1'b0;
    end else begin
      // S_DONE handles its own handoff of the output register
      if (result.valid && result.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (road_total < ROADS_CAP) begin
              road_total <= road_total + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
            if (road.last_road) begin
              idx   <= '0;
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          if (idx == cities) begin
            state <= S_SRC;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SRC: begin
          idx   <= '0;
          found <= 1'b0;
          state <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (idx == cities) begin
            idx   <= '0;
            total <= '0;
            state <= found ? S_MARK : S_CNT_RD;
          end else begin
            state <= S_SCAN_EV;
          end
        end
        S_SCAN_EV: begin
          if (!dist_rdata.settled && !dist_rdata.unreached &&
              (!found || dist_rdata.d < low)) begin
            low   <= dist_rdata.d;
            pick  <= idx[NODE_AW-1:0];
            found <= 1'b1;
          end
          idx   <= idx + 1'b1;
          state <= S_SCAN_RD;
        end
        S_MARK: begin
          found <= 1'b0;
          ridx  <= '0;
          state <= S_RX_RD;
        end
        S_RX_RD: begin
          if (ridx == road_total) begin
            idx   <= '0;
            state <= S_SCAN_RD;
          end else begin
            state <= S_RX_ROAD;
          end
        end
        S_RX_ROAD: begin
          if (hit_a || hit_b) begin
            other <= hit_a ? b_m1[NODE_AW-1:0] : a_m1[NODE_AW-1:0];
            rlen  <= road_rdata.len;
            state <= S_RX_DIST;
          end else begin
            ridx  <= ridx + 1'b1;
            state <= S_RX_RD;
          end
        end
        S_RX_DIST: begin
          ridx  <= ridx + 1'b1;
          state <= S_RX_RD;
        end
        S_CNT_RD: begin
          if (idx == cities) begin
            ridx  <= '0;
            state <= S_CR_RD;
          end else begin
            state <= S_CNT_EV;
          end
        end
        S_CNT_EV: begin
          if (dist_ext(dist_rdata) == {{(EXT_W-TGT_W){1'b0}}, target_distance}) begin
            total <= total + 1'b1;
          end
          idx   <= idx + 1'b1;
          state <= S_CNT_RD;
        end
        S_CR_RD: begin
          state <= (ridx == road_total) ? S_DONE : S_CR_A;
        end
        S_CR_A: begin
          if (road_ok) begin
            rb    <= road_rdata.b;
            rlen  <= road_rdata.len;
            state <= S_CR_B;
          end else begin
            ridx  <= ridx + 1'b1;
            state <= S_CR_RD;
          end
        end
        S_CR_B: begin
          dx    <= dist_ext(dist_rdata);
          state <= S_CR_J;
        end
        S_CR_J: begin
          total <= total + {{(CNT_W-2){1'b0}}, add};
          ridx  <= ridx + 1'b1;
          state <= S_CR_RD;
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid     <= 1'b1;
            res_count     <= total;
            res_over      <= overflow_seen;
            road_total    <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SPDC_ASSERT_NOW(a_total_cap, 1'b1, road_total <= ROADS_CAP, "road count past capacity")
  `SPDC_ASSERT_NOW(a_mark_found, state == S_MARK, found, "settling with no city picked")
  `SPDC_ASSERT_NEXT(a_last_starts, accept && road.last_road, state == S_INIT, "last road did not start run")
  `SPDC_ASSERT_NEXT(a_done_emits, state == S_DONE && !res_valid, res_valid && state == S_IDLE, "finished run not emitted")
endmodule
`default_nettype wire
